[design/sm83_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_pkg
// Shared types, register codes and accumulator arithmetic for the SM83 core.
// ----------------------------------------------------------------------------
package sm83_pkg;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_OPCODE  = 3'd1,
		PH_IMM     = 3'd2,
		PH_IMMHI   = 3'd3,
		PH_MEM     = 3'd4,
		PH_WRSP    = 3'd5,
		PH_AFTERWR = 3'd6
	} phase_t;

	localparam logic [2:0] R_H = 3'd4;
	localparam logic [2:0] R_L = 3'd5;
	localparam logic [2:0] R_F = 3'd6;
	localparam logic [2:0] R_A = 3'd7;

	localparam logic [7:0] F_Z = 8'h80;
	localparam logic [7:0] F_N = 8'h40;
	localparam logic [7:0] F_H = 8'h20;
	localparam logic [7:0] F_C = 8'h10;

	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBC = 3'd3;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR  = 3'd6;
	localparam logic [2:0] ALU_CP  = 3'd7;

	localparam logic [7:0] OP_RLCA = 8'h07;
	localparam logic [7:0] OP_RRCA = 8'h0F;
	localparam logic [7:0] OP_RLA  = 8'h17;
	localparam logic [7:0] OP_RRA  = 8'h1F;
	localparam logic [7:0] OP_DAA  = 8'h27;
	localparam logic [7:0] OP_CPL  = 8'h2F;
	localparam logic [7:0] OP_SCF  = 8'h37;
	localparam logic [7:0] OP_CCF  = 8'h3F;
	localparam logic [7:0] OP_LDSP = 8'h08;
	localparam logic [7:0] OP_JR   = 8'h18;
	localparam logic [7:0] OP_INCM = 8'h34;
	localparam logic [7:0] OP_DECM = 8'h35;
	localparam logic [7:0] OP_HALT = 8'h76;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] f;
	} af_t;

	function automatic af_t alu8(input logic [2:0] op, input logic [7:0] a,
			input logic [7:0] f, input logic [7:0] v);
		logic       c;
		logic [8:0] r;
		logic [8:0] sub;
		logic [4:0] hs;
		af_t        res;
		c = f[4];
		if (op == ALU_ADD || op == ALU_SUB || op == ALU_CP) begin
			c = 1'b0;
		end
		res.a = a;
		res.f = 8'h00;
		r = 9'd0;
		sub = {1'b0, v} + {8'd0, c};
		hs = {1'b0, v[3:0]} + {4'd0, c};
		case (op)
			ALU_ADD, ALU_ADC: begin
				r = {1'b0, a} + {1'b0, v} + {8'd0, c};
				res.f[5] = ({1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c}) > 5'd15;
				res.f[4] = r[8];
			end
			ALU_SUB, ALU_SBC, ALU_CP: begin
				r = {1'b0, a} - sub;
				res.f[6] = 1'b1;
				res.f[5] = {1'b0, a[3:0]} < hs;
				res.f[4] = {1'b0, a} < sub;
			end
			ALU_AND: begin
				r = {1'b0, a & v};
				res.f = F_H;
			end
			ALU_XOR: r = {1'b0, a ^ v};
			default: r = {1'b0, a | v};
		endcase
		if (r[7:0] == 8'h00) begin
			res.f = res.f | F_Z;
		end
		if (op != ALU_CP) begin
			res.a = r[7:0];
		end
		return res;
	endfunction

	function automatic af_t acc_misc(input logic [7:0] op, input logic [7:0] a_in,
			input logic [7:0] f_in);
		logic [7:0] a;
		logic [7:0] f;
		logic       c;
		af_t        res;
		a = a_in;
		f = f_in;
		c = f_in[4];
		case (op)
			OP_RLCA: begin f = a[7] ? F_C : 8'h00; a = {a[6:0], a[7]}; end
			OP_RRCA: begin f = a[0] ? F_C : 8'h00; a = {a[0], a[7:1]}; end
			OP_RLA:  begin f = a[7] ? F_C : 8'h00; a = {a[6:0], c}; end
			OP_RRA:  begin f = a[0] ? F_C : 8'h00; a = {c, a[7:1]}; end
			OP_DAA: begin
				if (!f[6]) begin
					if (c || a > 8'h99) begin
						a = a + 8'h60;
						c = 1'b1;
					end
					if (f[5] || a[3:0] > 4'd9) begin
						a = a + 8'h06;
					end
				end else begin
					if (c) begin
						a = a - 8'h60;
					end
					if (f[5]) begin
						a = a - 8'h06;
					end
				end
				f = (f & F_N) | ((a == 8'h00) ? F_Z : 8'h00) | (c ? F_C : 8'h00);
			end
			OP_CPL: begin a = ~a; f = f | F_N | F_H; end
			OP_SCF: f = (f & F_Z) | F_C;
			OP_CCF: f = (f & F_Z) | (c ? 8'h00 : F_C);
			default: ;
		endcase
		res.a = a;
		res.f = f & 8'hF0;
		return res;
	endfunction

endpackage

[design/sm83_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_front
// Two-entry queue that takes returned read bytes and hands them to the core.
// ----------------------------------------------------------------------------
module sm83_front import sm83_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] read_data,
	output logic       q_valid,
	input  logic       q_pop,
	output logic [7:0] q_data
);

	logic [7:0] mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// The queue never holds more than its two entries.
	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("front queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty front queue");
	assert property (@(posedge clk) disable iff (!arst_n)
			(push && !q_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("front queue count did not grow on push");

endmodule

[design/sm83_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_exec
// Executes one bus cycle per queued byte and registers the next bus request.
// ----------------------------------------------------------------------------
module sm83_exec import sm83_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] start_pc,
	input  logic        q_valid,
	output logic        q_pop,
	input  logic [7:0]  q_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] bus_address,
	output logic        bus_write,
	output logic [7:0]  write_data,
	output logic        opcode_fetch
);

	logic [7:0]  rf_q [8];
	logic [15:0] sp_q;
	logic [15:0] pc_q;
	logic [7:0]  op_q;
	phase_t      phase_q;
	logic [15:0] latch_q;
	logic        out_valid_q;
	logic [15:0] addr_q;
	logic        wr_q;
	logic [7:0]  wdata_q;
	logic        fetch_q;

	logic [7:0]  rf_n [8];
	logic [15:0] sp_n;
	logic [15:0] pc_n;
	logic [7:0]  op_n;
	phase_t      phase_n;
	logic [15:0] latch_n;
	logic [15:0] o_addr;
	logic        o_wr;
	logic [7:0]  o_data;
	logic        o_fetch;

	assign q_pop        = q_valid && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;
	assign bus_address  = addr_q;
	assign bus_write    = wr_q;
	assign write_data   = wdata_q;
	assign opcode_fetch = fetch_q;

	always_comb begin
		logic [7:0]  v;
		logic [2:0]  dst;
		logic [2:0]  src;
		logic [1:0]  pair;
		logic [15:0] hl;
		logic [15:0] r16;
		logic [16:0] sum;
		logic [12:0] half;
		logic        do_fetch;
		logic        flag;
		logic        take;
		logic [15:0] word;
		af_t         af;
		v = q_data;
		for (int i = 0; i < 8; i++) begin
			rf_n[i] = rf_q[i];
		end
		sp_n     = sp_q;
		pc_n     = pc_q;
		op_n     = op_q;
		phase_n  = phase_q;
		latch_n  = latch_q;
		o_addr   = pc_q;
		o_wr     = 1'b0;
		o_data   = 8'h00;
		o_fetch  = 1'b0;
		do_fetch = 1'b0;
		dst      = op_q[5:3];
		src      = op_q[2:0];
		pair     = op_q[5:4];
		hl       = {rf_q[R_H], rf_q[R_L]};
		r16      = 16'h0000;
		sum      = 17'd0;
		half     = 13'd0;
		flag     = 1'b0;
		take     = 1'b1;
		word     = {v, latch_q[7:0]};
		af       = '{a: rf_q[R_A], f: rf_q[R_F]};
		case (phase_q)
			PH_START: begin
				pc_n = start_pc;
				do_fetch = 1'b1;
			end
			PH_OPCODE: begin
				op_n = v;
				dst  = v[5:3];
				src  = v[2:0];
				pair = v[5:4];
				case (pair)
					2'd0: r16 = {rf_q[0], rf_q[1]};
					2'd1: r16 = {rf_q[2], rf_q[3]};
					2'd2: r16 = hl;
					default: r16 = sp_q;
				endcase
				if (v[7:6] == 2'b00) begin
					if (src == 3'd7) begin
						af = acc_misc(v, rf_q[R_A], rf_q[R_F]);
						rf_n[R_A] = af.a;
						rf_n[R_F] = af.f;
						do_fetch = 1'b1;
					end else if (v == OP_LDSP || v == OP_JR || (v & 8'hE7) == 8'h20
							|| (v & 8'hCF) == 8'h01 || src == 3'd6) begin
						pc_n = pc_q + 16'd1;
						phase_n = PH_IMM;
					end else if (v[3:0] == 4'h2 || v[3:0] == 4'hA) begin
						if (pair[1]) begin
							o_addr = hl;
							r16 = pair[0] ? hl - 16'd1 : hl + 16'd1;
							rf_n[R_H] = r16[15:8];
							rf_n[R_L] = r16[7:0];
						end else begin
							o_addr = r16;
						end
						if (!v[3]) begin
							o_wr = 1'b1;
							o_data = rf_q[R_A];
							phase_n = PH_AFTERWR;
						end else begin
							phase_n = PH_MEM;
						end
					end else begin
						do_fetch = 1'b1;
						if (v[3:0] == 4'h3 || v[3:0] == 4'hB || v[3:0] == 4'h9) begin
							if (v[3:0] == 4'h3) begin
								sum = {1'b0, r16} + 17'd1;
							end else if (v[3:0] == 4'hB) begin
								sum = {1'b0, r16} - 17'd1;
							end else begin
								sum = {1'b0, hl} + {1'b0, r16};
								half = {1'b0, hl[11:0]} + {1'b0, r16[11:0]};
							end
							if (v[3:0] == 4'h9) begin
								rf_n[R_H] = sum[15:8];
								rf_n[R_L] = sum[7:0];
								rf_n[R_F] = (rf_q[R_F] & F_Z) | (half[12] ? F_H : 8'h00)
									| (sum[16] ? F_C : 8'h00);
							end else if (pair == 2'd3) begin
								sp_n = sum[15:0];
							end else begin
								rf_n[{pair, 1'b0}] = sum[15:8];
								rf_n[{pair, 1'b1}] = sum[7:0];
							end
						end else if (src == 3'd4 || src == 3'd5) begin
							if (dst == 3'd6) begin
								do_fetch = 1'b0;
								o_addr = hl;
								phase_n = PH_MEM;
							end else if (src == 3'd4) begin
								rf_n[dst] = rf_q[dst] + 8'd1;
								rf_n[R_F] = (rf_q[R_F] & F_C)
									| ((rf_n[dst] == 8'h00) ? F_Z : 8'h00)
									| ((rf_q[dst][3:0] == 4'hF) ? F_H : 8'h00);
							end else begin
								rf_n[dst] = rf_q[dst] - 8'd1;
								rf_n[R_F] = (rf_q[R_F] & F_C) | F_N
									| ((rf_n[dst] == 8'h00) ? F_Z : 8'h00)
									| ((rf_q[dst][3:0] == 4'h0) ? F_H : 8'h00);
							end
						end
					end
				end else if (v[7:6] == 2'b01) begin
					if (v == OP_HALT) begin
						do_fetch = 1'b1;
					end else if (src == 3'd6) begin
						o_addr = hl;
						phase_n = PH_MEM;
					end else if (dst == 3'd6) begin
						o_addr = hl;
						o_wr = 1'b1;
						o_data = rf_q[src];
						phase_n = PH_AFTERWR;
					end else begin
						rf_n[dst] = rf_q[src];
						do_fetch = 1'b1;
					end
				end else if (v[7:6] == 2'b10) begin
					if (src == 3'd6) begin
						o_addr = hl;
						phase_n = PH_MEM;
					end else begin
						af = alu8(dst, rf_q[R_A], rf_q[R_F], rf_q[src]);
						rf_n[R_A] = af.a;
						rf_n[R_F] = af.f;
						do_fetch = 1'b1;
					end
				end else if (src == 3'd6) begin
					pc_n = pc_q + 16'd1;
					phase_n = PH_IMM;
				end else begin
					do_fetch = 1'b1;
				end
			end
			PH_IMM: begin
				do_fetch = 1'b1;
				if ((op_q & 8'hCF) == 8'h01 || op_q == OP_LDSP) begin
					do_fetch = 1'b0;
					latch_n = {8'h00, v};
					pc_n = pc_q + 16'd1;
					phase_n = PH_IMMHI;
				end else if (op_q == OP_JR || (op_q & 8'hE7) == 8'h20) begin
					if (op_q != OP_JR) begin
						flag = dst[1] ? rf_q[R_F][4] : rf_q[R_F][7];
						take = dst[0] ? flag : !flag;
					end
					if (take) begin
						pc_n = pc_q + {{8{v[7]}}, v};
					end
				end else if ((op_q & 8'hC7) == 8'h06) begin
					if (dst == 3'd6) begin
						do_fetch = 1'b0;
						o_addr = hl;
						o_wr = 1'b1;
						o_data = v;
						phase_n = PH_AFTERWR;
					end else begin
						rf_n[dst] = v;
					end
				end else if ((op_q & 8'hC7) == 8'hC6) begin
					af = alu8(dst, rf_q[R_A], rf_q[R_F], v);
					rf_n[R_A] = af.a;
					rf_n[R_F] = af.f;
				end
			end
			PH_IMMHI: begin
				if (op_q == OP_LDSP) begin
					o_addr = word;
					o_wr = 1'b1;
					o_data = sp_q[7:0];
					latch_n = word;
					phase_n = PH_WRSP;
				end else begin
					do_fetch = 1'b1;
					if (pair == 2'd3) begin
						sp_n = word;
					end else begin
						rf_n[{pair, 1'b0}] = v;
						rf_n[{pair, 1'b1}] = latch_q[7:0];
					end
				end
			end
			PH_MEM: begin
				do_fetch = 1'b1;
				if (op_q[7:6] == 2'b00) begin
					if (op_q == OP_INCM || op_q == OP_DECM) begin
						do_fetch = 1'b0;
						o_data = (op_q == OP_INCM) ? v + 8'd1 : v - 8'd1;
						if (op_q == OP_INCM) begin
							rf_n[R_F] = (rf_q[R_F] & F_C)
								| ((o_data == 8'h00) ? F_Z : 8'h00)
								| ((v[3:0] == 4'hF) ? F_H : 8'h00);
						end else begin
							rf_n[R_F] = (rf_q[R_F] & F_C) | F_N
								| ((o_data == 8'h00) ? F_Z : 8'h00)
								| ((v[3:0] == 4'h0) ? F_H : 8'h00);
						end
						o_addr = hl;
						o_wr = 1'b1;
						phase_n = PH_AFTERWR;
					end else begin
						rf_n[R_A] = v;
					end
				end else if (op_q[7:6] == 2'b01) begin
					if (dst != 3'd6) begin
						rf_n[dst] = v;
					end
				end else begin
					af = alu8(dst, rf_q[R_A], rf_q[R_F], v);
					rf_n[R_A] = af.a;
					rf_n[R_F] = af.f;
				end
			end
			PH_WRSP: begin
				// The byte on the queue is ignored here; the address comes from the latch.
				o_addr = latch_q + 16'd1;
				o_wr = 1'b1;
				o_data = sp_q[15:8];
				phase_n = PH_AFTERWR;
			end
			default: do_fetch = 1'b1;
		endcase
		if (do_fetch) begin
			o_addr = pc_n;
			o_fetch = 1'b1;
			pc_n = pc_n + 16'd1;
			phase_n = PH_OPCODE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= 8'h00;
			end
			sp_q        <= 16'h0000;
			pc_q        <= 16'h0000;
			op_q        <= 8'h00;
			phase_q     <= PH_START;
			latch_q     <= 16'h0000;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				for (int i = 0; i < 8; i++) begin
					rf_q[i] <= rf_n[i];
				end
				sp_q        <= sp_n;
				pc_q        <= pc_n;
				op_q        <= op_n;
				phase_q     <= phase_n;
				latch_q     <= latch_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_q  <= o_addr;
			wr_q    <= o_wr;
			wdata_q <= o_data;
			fetch_q <= o_fetch;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid && opcode_fetch) |-> !bus_write)
		else $error("opcode fetch marked as write");
	assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid && !bus_write) |-> write_data == 8'h00)
		else $error("read request carries write data");
	assert property (@(posedge clk) disable iff (!arst_n)
			$past(q_pop) && bus_write |-> (phase_q == PH_AFTERWR || phase_q == PH_WRSP))
		else $error("write request not followed by write phase");
	assert property (@(posedge clk) disable iff (!arst_n)
			$past(q_pop) && opcode_fetch |-> phase_q == PH_OPCODE)
		else $error("fetch issued without entering opcode phase");

endmodule

[design/sm83_cpu_core_bus_cycle_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_cpu_core_bus_cycle_unit
// SM83 core subset driven one memory bus cycle at a time.
// ----------------------------------------------------------------------------
// A read byte accepted into the input queue has its bus request registered in the output register when it is popped.
// Throughput: one bus cycle per clock while the output is not stalled; the combinational execute step sets the rate.
// The two-entry input queue and the output register let each side stall alone.
// Reset clears registers, SP, PC and the phase; the first item starts at start_pc.
module sm83_cpu_core_bus_cycle_unit import sm83_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] bus_address,
	output logic        bus_write,
	output logic [7:0]  write_data,
	output logic        opcode_fetch
);

	logic [15:0] start_pc_q;
	logic        q_valid;
	logic        q_pop;
	logic [7:0]  q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= 16'h0000;
		end else if (cfg_we) begin
			start_pc_q <= cfg_data;
		end
	end

	sm83_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.read_data (read_data),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data)
	);

	sm83_exec u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_pc     (start_pc_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_data       (q_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bus_address  (bus_address),
		.bus_write    (bus_write),
		.write_data   (write_data),
		.opcode_fetch (opcode_fetch)
	);

endmodule

[verif/sm83_cpu_core_bus_cycle_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm83_cpu_core_bus_cycle_unit_tb
// Feeds read bytes into the core one bus cycle per beat and checks every bus
// request against an in-bench model of the instruction subset, under random
// stalls on both sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module sm83_cpu_core_bus_cycle_unit_tb;
	import sm83_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [15:0] addr;
		logic        wr;
		logic [7:0]  wdata;
		logic        fetch;
	} bus_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = 16'h0000;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  read_data = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] bus_address;
	logic        bus_write;
	logic [7:0]  write_data;
	logic        opcode_fetch;

	sm83_cpu_core_bus_cycle_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .read_data(read_data),
		.out_valid(out_valid), .out_ready(out_ready), .bus_address(bus_address),
		.bus_write(bus_write), .write_data(write_data), .opcode_fetch(opcode_fetch)
	);

	always #4 clk = ~clk;

	// CPU model state
	logic [7:0]  gpr [8];
	logic [15:0] sp_q, pc_q, latch_q, start_addr;
	logic [7:0]  op_q;
	phase_t      phase_q;
	bus_req_t    req;

	bus_req_t    pending_reqs [$];
	int          errors = 0;
	int          cycles = 0;
	bit          calm = 1'b0;
	int          hold_seq = 0;
	int          hold_seen = 0;
	int          hold_cnt = 0;
	int          stall_cnt = 0;

	function automatic void issue(input logic [15:0] a, input logic w, input logic [7:0] d,
			input logic f);
		req.addr = a;
		req.wr = w;
		req.wdata = w ? d : 8'h00;
		req.fetch = f;
	endfunction

	function automatic void fetch_next();
		issue(pc_q, 1'b0, 8'h00, 1'b1);
		pc_q = pc_q + 16'd1;
		phase_q = PH_OPCODE;
	endfunction

	function automatic void read_operand(input phase_t nxt);
		issue(pc_q, 1'b0, 8'h00, 1'b0);
		pc_q = pc_q + 16'd1;
		phase_q = nxt;
	endfunction

	function automatic logic [15:0] hl_val();
		return {gpr[R_H], gpr[R_L]};
	endfunction

	function automatic void put_hl(input logic [15:0] v);
		gpr[R_H] = v[15:8];
		gpr[R_L] = v[7:0];
	endfunction

	function automatic logic [15:0] pair_val(input logic [1:0] i);
		if (i == 2'd3) return sp_q;
		return {gpr[{i, 1'b0}], gpr[{i, 1'b1}]};
	endfunction

	function automatic void put_pair(input logic [1:0] i, input logic [15:0] v);
		if (i == 2'd3) begin
			sp_q = v;
		end else begin
			gpr[{i, 1'b0}] = v[15:8];
			gpr[{i, 1'b1}] = v[7:0];
		end
	endfunction

	// BC, DE, then HL with post-increment or post-decrement.
	function automatic logic [15:0] indirect_addr(input logic [1:0] i);
		logic [15:0] a;
		if (i < 2'd2) return pair_val(i);
		a = hl_val();
		put_hl(i == 2'd2 ? a + 16'd1 : a - 16'd1);
		return a;
	endfunction

	function automatic void acc_alu(input logic [2:0] op, input logic [7:0] v);
		int a, c, r, f;
		a = gpr[R_A];
		c = gpr[R_F][4];
		if (op == ALU_ADD || op == ALU_SUB || op == ALU_CP) c = 0;
		case (op)
			ALU_ADD, ALU_ADC: begin
				r = a + v + c;
				f = (((a & 15) + (v & 15) + c) > 15 ? F_H : 0) | (r > 255 ? F_C : 0);
			end
			ALU_SUB, ALU_SBC, ALU_CP: begin
				r = (a - v - c) & 255;
				f = F_N | ((a & 15) < (v & 15) + c ? F_H : 0) | (a < v + c ? F_C : 0);
			end
			ALU_AND: begin r = a & v; f = F_H; end
			ALU_XOR: begin r = a ^ v; f = 0; end
			default: begin r = a | v; f = 0; end
		endcase
		r = r & 255;
		if (r == 0) f = f | F_Z;
		gpr[R_F] = f[7:0];
		if (op != ALU_CP) gpr[R_A] = r[7:0];
	endfunction

	function automatic logic [7:0] step_byte(input logic [7:0] v, input bit down);
		logic [7:0] r;
		r = down ? v - 8'd1 : v + 8'd1;
		gpr[R_F] = (gpr[R_F] & F_C) | (down ? F_N : 8'h00) | (r == 8'h00 ? F_Z : 8'h00)
			| ((down ? v[3:0] == 4'h0 : v[3:0] == 4'hF) ? F_H : 8'h00);
		return r;
	endfunction

	function automatic void acc_rotate_misc(input logic [7:0] op);
		int a, f, c, nc;
		a = gpr[R_A];
		f = gpr[R_F];
		c = f[4];
		case (op)
			OP_RLCA: begin nc = a >> 7; a = (a << 1) | nc; f = nc ? F_C : 0; end
			OP_RRCA: begin nc = a & 1; a = (a >> 1) | (nc << 7); f = nc ? F_C : 0; end
			OP_RLA:  begin nc = a >> 7; a = (a << 1) | c; f = nc ? F_C : 0; end
			OP_RRA:  begin nc = a & 1; a = (a >> 1) | (c << 7); f = nc ? F_C : 0; end
			OP_DAA: begin
				if ((f & F_N) == 0) begin
					if (c != 0 || a > 'h99) begin a = a + 'h60; c = 1; end
					if ((f & F_H) != 0 || (a & 'h0F) > 9) a = a + 'h06;
				end else begin
					if (c != 0) a = a - 'h60;
					if ((f & F_H) != 0) a = a - 'h06;
				end
				a = a & 255;
				f = (f & F_N) | (a == 0 ? F_Z : 0) | (c != 0 ? F_C : 0);
			end
			OP_CPL: begin a = ~a; f = f | F_N | F_H; end
			OP_SCF: f = (f & F_Z) | F_C;
			OP_CCF: f = (f & F_Z) | (c != 0 ? 0 : F_C);
			default: ;
		endcase
		gpr[R_A] = a[7:0];
		gpr[R_F] = f[7:0] & 8'hF0;
	endfunction

	function automatic void decode_opcode(input logic [7:0] op);
		logic [2:0]  dst, src;
		logic [1:0]  pr;
		logic [16:0] sum;
		logic [12:0] half;
		logic [15:0] hv, pv;
		dst = op[5:3];
		src = op[2:0];
		pr = op[5:4];
		op_q = op;
		if (op[7:6] == 2'b00) begin
			if (src == 3'd7) begin acc_rotate_misc(op); fetch_next(); return; end
			if (op == OP_LDSP || op == OP_JR || (op & 8'hE7) == 8'h20
					|| op[3:0] == 4'h1 || src == 3'd6) begin
				read_operand(PH_IMM);
				return;
			end
			if (op[3:0] == 4'h2) begin
				issue(indirect_addr(pr), 1'b1, gpr[R_A], 1'b0);
				phase_q = PH_AFTERWR;
				return;
			end
			if (op[3:0] == 4'hA) begin
				issue(indirect_addr(pr), 1'b0, 8'h00, 1'b0);
				phase_q = PH_MEM;
				return;
			end
			if (op[3:0] == 4'h3) begin
				put_pair(pr, pair_val(pr) + 16'd1);
			end else if (op[3:0] == 4'hB) begin
				put_pair(pr, pair_val(pr) - 16'd1);
			end else if (op[3:0] == 4'h9) begin
				hv = hl_val();
				pv = pair_val(pr);
				half = {1'b0, hv[11:0]} + {1'b0, pv[11:0]};
				sum = {1'b0, hv} + {1'b0, pv};
				put_hl(sum[15:0]);
				gpr[R_F] = (gpr[R_F] & F_Z) | (half[12] ? F_H : 8'h00)
					| (sum[16] ? F_C : 8'h00);
			end else if (src == 3'd4 || src == 3'd5) begin
				if (dst == 3'd6) begin
					issue(hl_val(), 1'b0, 8'h00, 1'b0);
					phase_q = PH_MEM;
					return;
				end
				gpr[dst] = step_byte(gpr[dst], src == 3'd5);
			end
			fetch_next();
			return;
		end
		if (op[7:6] == 2'b01) begin
			if (op != OP_HALT) begin
				if (src == 3'd6) begin
					issue(hl_val(), 1'b0, 8'h00, 1'b0);
					phase_q = PH_MEM;
					return;
				end
				if (dst == 3'd6) begin
					issue(hl_val(), 1'b1, gpr[src], 1'b0);
					phase_q = PH_AFTERWR;
					return;
				end
				gpr[dst] = gpr[src];
			end
			fetch_next();
			return;
		end
		if (op[7:6] == 2'b10) begin
			if (src == 3'd6) begin
				issue(hl_val(), 1'b0, 8'h00, 1'b0);
				phase_q = PH_MEM;
				return;
			end
			acc_alu(dst, gpr[src]);
			fetch_next();
			return;
		end
		if (src == 3'd6) begin read_operand(PH_IMM); return; end
		fetch_next();
	endfunction

	function automatic void take_immediate(input logic [7:0] v);
		logic [2:0] dst;
		logic       flag, jump;
		dst = op_q[5:3];
		if (op_q[3:0] == 4'h1 && op_q[7:6] == 2'b00 || op_q == OP_LDSP) begin
			latch_q = {8'h00, v};
			read_operand(PH_IMMHI);
			return;
		end
		if (op_q == OP_JR || (op_q & 8'hE7) == 8'h20) begin
			jump = 1'b1;
			if (op_q != OP_JR) begin
				flag = dst[1] ? gpr[R_F][4] : gpr[R_F][7];
				jump = dst[0] ? flag : !flag;
			end
			if (jump) pc_q = pc_q + {{8{v[7]}}, v};
		end else if ((op_q & 8'hC7) == 8'h06) begin
			if (dst == 3'd6) begin
				issue(hl_val(), 1'b1, v, 1'b0);
				phase_q = PH_AFTERWR;
				return;
			end
			gpr[dst] = v;
		end else if ((op_q & 8'hC7) == 8'hC6) begin
			acc_alu(dst, v);
		end
		fetch_next();
	endfunction

	function automatic void take_memory_byte(input logic [7:0] v);
		if (op_q[7:6] == 2'b00) begin
			if (op_q == OP_INCM || op_q == OP_DECM) begin
				issue(hl_val(), 1'b1, step_byte(v, op_q == OP_DECM), 1'b0);
				phase_q = PH_AFTERWR;
				return;
			end
			gpr[R_A] = v;
		end else if (op_q[7:6] == 2'b01) begin
			if (op_q[5:3] != 3'd6) gpr[op_q[5:3]] = v;
		end else begin
			acc_alu(op_q[5:3], v);
		end
		fetch_next();
	endfunction

	function automatic bus_req_t next_bus_request(input logic [7:0] v);
		case (phase_q)
			PH_START: begin pc_q = start_addr; fetch_next(); end
			PH_OPCODE: decode_opcode(v);
			PH_IMM: take_immediate(v);
			PH_IMMHI: begin
				if (op_q == OP_LDSP) begin
					latch_q = {v, latch_q[7:0]};
					issue(latch_q, 1'b1, sp_q[7:0], 1'b0);
					phase_q = PH_WRSP;
				end else begin
					put_pair(op_q[5:4], {v, latch_q[7:0]});
					fetch_next();
				end
			end
			PH_MEM: take_memory_byte(v);
			PH_WRSP: begin
				issue(latch_q + 16'd1, 1'b1, sp_q[15:8], 1'b0);
				phase_q = PH_AFTERWR;
			end
			default: fetch_next();
		endcase
		return req;
	endfunction

	// Scoreboard: results are compared before the new beat is predicted.
	always @(posedge clk) begin
		bus_req_t want;
		if (arst_n) begin
			if (cfg_we) start_addr <= cfg_data;
			if (out_valid && out_ready) begin
				if (pending_reqs.size() == 0) begin
					$display("%0t: unexpected request addr=%h wr=%b data=%h fetch=%b",
						$time, bus_address, bus_write, write_data, opcode_fetch);
					errors++;
				end else begin
					want = pending_reqs.pop_front();
					if (bus_address !== want.addr) begin
						$display("%0t: bus_address expected %h actual %h",
							$time, want.addr, bus_address);
						errors++;
					end
					if (bus_write !== want.wr) begin
						$display("%0t: bus_write expected %b actual %b",
							$time, want.wr, bus_write);
						errors++;
					end
					if (write_data !== want.wdata) begin
						$display("%0t: write_data expected %h actual %h",
							$time, want.wdata, write_data);
						errors++;
					end
					if (opcode_fetch !== want.fetch) begin
						$display("%0t: opcode_fetch expected %b actual %b",
							$time, want.fetch, opcode_fetch);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) pending_reqs.push_back(next_bus_request(read_data));
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_cnt <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_cnt <= $urandom_range(0, 11);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sm83_cpu_core_bus_cycle_unit test failed");
			$finish;
		end
	end

	task automatic send_beat(input logic [7:0] b, input bit may_idle);
		in_valid <= 1'b1;
		read_data <= b;
		do @(posedge clk); while (!in_ready);
		if (may_idle && !calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reqs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_pc(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_byte();
		logic [7:0] edge_vals [8] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h0F, 8'hF0, 8'h99, 8'h01};
		case ($urandom_range(0, 3))
			0: return edge_vals[$urandom_range(0, 7)];
			1: return 8'($urandom_range(0, 8'h3F));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [7:0] prog [25] = '{8'h00, 8'h3E, 8'hFF, 8'hC6, 8'h01, 8'h27, 8'h06, 8'h80,
			8'h90, 8'hCE, 8'hFF, 8'h21, 8'hFF, 8'hFF, 8'h34, 8'h55, 8'h00, 8'h08, 8'hFF,
			8'hFF, 8'h00, 8'h00, 8'h00, 8'h18, 8'hFE};
		foreach (prog[i]) send_beat(prog[i], 1'b0);
	endtask

	task automatic test_random(input int n);
		repeat (n) send_beat(random_byte(), 1'b1);
	endtask

	// Output held off long enough that the input queue fills and stalls.
	task automatic test_output_holdoff();
		hold_seq = hold_seq + 1;
		repeat (30) send_beat(random_byte(), 1'b0);
	endtask

	task automatic test_start_pc_writes();
		wait_drained();
		write_start_pc(16'h0000);
		test_random(100);
		wait_drained();
		write_start_pc(16'($urandom));
	endtask

	initial begin
		start_addr = 16'h0000;
		for (int i = 0; i < 8; i++) gpr[i] = 8'h00;
		sp_q = 16'h0000;
		pc_q = 16'h0000;
		latch_q = 16'h0000;
		op_q = 8'h00;
		phase_q = PH_START;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The first fetch comes from the top of memory so that PC wraps.
		write_start_pc(16'hFFFF);
		test_directed();
		test_random(600);
		test_output_holdoff();
		wait_drained();
		test_start_pc_writes();
		test_random(500);
		calm = 1'b1;
		test_random(200);
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("sm83_cpu_core_bus_cycle_unit test passed");
		end else begin
			$display("sm83_cpu_core_bus_cycle_unit test failed");
		end
		$finish;
	end

endmodule
